// ===== rtl/caa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package caa_pkg;

   localparam int unsigned DIV_STEPS = 32;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2,
      STATUS_UNUSED   = 2'd3
   } status_type;

   // per-word sideband carried alongside the divider
   typedef struct packed {
      mode_type    mode;
      logic        dz;
      logic        neg_re;
      logic        neg_im;
      logic        sat_re;
      logic        sat_im;
      logic [31:0] res_re;
      logic [31:0] res_im;
      logic        ovf;
   } side_type;

   // saturating sign/magnitude to Q16.16; bit 32 is the overflow flag
   function automatic logic [32:0] pack(input logic neg, input logic [47:0] mag);
      logic [32:0] r;
      if (!neg) begin
         if (mag > 48'h0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else                          r = {1'b0, mag[31:0]};
      end else begin
         if (mag > 48'h0000_8000_0000) r = {1'b1, 32'h8000_0000};
         else                          r = {1'b0, 32'd0 - mag[31:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/caa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage: floor(num * 2^16 / den)
module caa_div (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic      [31:0] quot
);

   localparam int unsigned N = caa_pkg::DIV_STEPS;

   logic [63:0] r_ff   [N+1];
   logic [63:0] den_ff [N+1];
   logic [31:0] low_ff [N+1];
   logic [31:0] q_ff   [N+1];

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= {16'd0, num[63:16]};
         den_ff[0] <= den;
         low_ff[0] <= {num[15:0], 16'd0};
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [64:0] t;
      logic        ge;
      logic [64:0] d;
      assign t  = {r_ff[k], low_ff[k][31]};
      assign ge = t >= {1'b0, den_ff[k]};
      assign d  = t - {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]   <= ge ? d[63:0] : t[63:0];
            den_ff[k+1] <= den_ff[k];
            low_ff[k+1] <= {low_ff[k][30:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][30:0], ge};
         end
      end
   end

   assign quot = q_ff[N];

endmodule

`default_nettype wire

// ===== rtl/complex_arith_alu_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Complex ALU on signed Q16.16 operands: add, subtract, multiply, or divide
// (a * conj(b) / |b|^2). Fully pipelined: one word accepted per cycle while
// the pipe advances, each word passing 36 register stages (one multiplier
// stage, one summing stage, one magnitude stage, 32 stages of the
// bit-per-stage divider, one output register). All modes share the
// divider's latency so words leave in order. The whole pipe advances
// together whenever the output register is empty or being drained.
// Products and quotients truncate toward zero; out-of-range parts saturate
// with status 2; a zero divisor gives zero parts with status 1.
module complex_arith_alu_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic        [1:0]  req_mode,
   input  wire logic signed [31:0] req_a_re,
   input  wire logic signed [31:0] req_a_im,
   input  wire logic signed [31:0] req_b_re,
   input  wire logic signed [31:0] req_b_im,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed      [31:0] rsp_res_re,
   output logic signed      [31:0] rsp_res_im,
   output logic             [1:0]  rsp_status
);

   localparam int unsigned N = caa_pkg::DIV_STEPS;

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---- stage 1: products and raw sums
   logic                 v1_ff;
   caa_pkg::mode_type    mode1_ff;
   logic signed [63:0]   p_arbr_ff, p_aibi_ff, p_arbi_ff, p_aibr_ff, p_brbr_ff, p_bibi_ff;
   logic signed [32:0]   as_re_ff, as_im_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode1_ff  <= caa_pkg::mode_type'(req_mode);
         p_arbr_ff <= req_a_re * req_b_re;
         p_aibi_ff <= req_a_im * req_b_im;
         p_arbi_ff <= req_a_re * req_b_im;
         p_aibr_ff <= req_a_im * req_b_re;
         p_brbr_ff <= req_b_re * req_b_re;
         p_bibi_ff <= req_b_im * req_b_im;
         if (caa_pkg::mode_type'(req_mode) == caa_pkg::MODE_SUB) begin
            as_re_ff <= 33'(req_a_re) - 33'(req_b_re);
            as_im_ff <= 33'(req_a_im) - 33'(req_b_im);
         end else begin
            as_re_ff <= 33'(req_a_re) + 33'(req_b_re);
            as_im_ff <= 33'(req_a_im) + 33'(req_b_im);
         end
      end
   end

   // ---- stage 2: cross sums (exact, 66 bits), divisor, add/sub packing
   logic                 v2_ff;
   caa_pkg::mode_type    mode2_ff;
   logic signed [65:0]   sum_re_ff, sum_im_ff;
   logic [63:0]          den_ff;
   logic [31:0]          as_res_re_ff, as_res_im_ff;
   logic                 as_ovf_ff;

   logic signed [65:0] e_arbr, e_aibi, e_arbi, e_aibr;
   logic [32:0] pk_as_re, pk_as_im;
   logic [32:0] as_mag_re, as_mag_im;
   assign e_arbr = 66'(p_arbr_ff);
   assign e_aibi = 66'(p_aibi_ff);
   assign e_arbi = 66'(p_arbi_ff);
   assign e_aibr = 66'(p_aibr_ff);
   assign as_mag_re = as_re_ff[32] ? 33'd0 - as_re_ff : as_re_ff;
   assign as_mag_im = as_im_ff[32] ? 33'd0 - as_im_ff : as_im_ff;
   assign pk_as_re = caa_pkg::pack(as_re_ff[32], {15'd0, as_mag_re});
   assign pk_as_im = caa_pkg::pack(as_im_ff[32], {15'd0, as_mag_im});

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode2_ff <= mode1_ff;
         if (mode1_ff == caa_pkg::MODE_MUL) begin
            sum_re_ff <= e_arbr - e_aibi;
            sum_im_ff <= e_arbi + e_aibr;
         end else begin
            sum_re_ff <= e_arbr + e_aibi;
            sum_im_ff <= e_aibr - e_arbi;
         end
         den_ff       <= 64'(p_brbr_ff) + 64'(p_bibi_ff);
         as_res_re_ff <= pk_as_re[31:0];
         as_res_im_ff <= pk_as_im[31:0];
         as_ovf_ff    <= pk_as_re[32] | pk_as_im[32];
      end
   end

   // ---- stage 3: sign/magnitude, product packing, quotient range check
   logic        neg_re, neg_im;
   logic [65:0] mag_re_w, mag_im_w;
   logic [63:0] mag_re, mag_im;
   logic [32:0] pk_mul_re, pk_mul_im;
   caa_pkg::side_type side_in;

   assign neg_re   = sum_re_ff[65];
   assign neg_im   = sum_im_ff[65];
   assign mag_re_w = neg_re ? 66'd0 - sum_re_ff : sum_re_ff;
   assign mag_im_w = neg_im ? 66'd0 - sum_im_ff : sum_im_ff;
   assign mag_re   = mag_re_w[63:0];
   assign mag_im   = mag_im_w[63:0];
   assign pk_mul_re = caa_pkg::pack(neg_re, mag_re[63:16]);
   assign pk_mul_im = caa_pkg::pack(neg_im, mag_im[63:16]);

   always_comb begin
      side_in        = '0;
      side_in.mode   = mode2_ff;
      side_in.dz     = den_ff == 64'd0;
      side_in.neg_re = neg_re;
      side_in.neg_im = neg_im;
      // integer part of the quotient would need more than 16 bits
      side_in.sat_re = {16'd0, mag_re} >= {den_ff, 16'd0};
      side_in.sat_im = {16'd0, mag_im} >= {den_ff, 16'd0};
      if (mode2_ff == caa_pkg::MODE_MUL) begin
         side_in.res_re = pk_mul_re[31:0];
         side_in.res_im = pk_mul_im[31:0];
         side_in.ovf    = pk_mul_re[32] | pk_mul_im[32];
      end else begin
         side_in.res_re = as_res_re_ff;
         side_in.res_im = as_res_im_ff;
         side_in.ovf    = as_ovf_ff;
      end
   end

   // ---- divider stages; sideband and valid bits move in step with them
   logic [31:0] q_re, q_im;

   caa_div u_div_re (
      .clock (clock),
      .en    (adv),
      .num   (mag_re),
      .den   (den_ff),
      .quot  (q_re)
   );

   caa_div u_div_im (
      .clock (clock),
      .en    (adv),
      .num   (mag_im),
      .den   (den_ff),
      .quot  (q_im)
   );

   logic              dv_ff   [N+1];
   caa_pkg::side_type side_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v2_ff;
         for (int k = 0; k < N; k++) dv_ff[k+1] <= dv_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 0; k < N; k++) side_ff[k+1] <= side_ff[k];
      end
   end

   // ---- output register
   caa_pkg::side_type sd;
   logic [32:0]       pk_q_re, pk_q_im;
   logic [31:0]       res_re_in, res_im_in;
   caa_pkg::status_type status_in;

   assign sd      = side_ff[N];
   assign pk_q_re = caa_pkg::pack(sd.neg_re, sd.sat_re ? 48'hFFFF_FFFF_FFFF : {16'd0, q_re});
   assign pk_q_im = caa_pkg::pack(sd.neg_im, sd.sat_im ? 48'hFFFF_FFFF_FFFF : {16'd0, q_im});

   always_comb begin
      res_re_in = sd.res_re;
      res_im_in = sd.res_im;
      status_in = sd.ovf ? caa_pkg::STATUS_OVERFLOW : caa_pkg::STATUS_OK;
      if (sd.mode == caa_pkg::MODE_DIV) begin
         if (sd.dz) begin
            res_re_in = '0;
            res_im_in = '0;
            status_in = caa_pkg::STATUS_DIV_ZERO;
         end else begin
            res_re_in = pk_q_re[31:0];
            res_im_in = pk_q_im[31:0];
            status_in = (pk_q_re[32] | pk_q_im[32]) ? caa_pkg::STATUS_OVERFLOW
                                                    : caa_pkg::STATUS_OK;
         end
      end
   end

   logic        out_v_ff;
   logic [31:0] out_re_ff, out_im_ff;
   caa_pkg::status_type out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= dv_ff[N];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_re_ff <= res_re_in;
         out_im_ff <= res_im_in;
         out_st_ff <= status_in;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_res_re = out_re_ff;
   assign rsp_res_im = out_im_ff;
   assign rsp_status = out_st_ff;

   // ---- checks
   a_no_code3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != caa_pkg::STATUS_UNUSED)
      else $error("status code 3 produced");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == caa_pkg::STATUS_DIV_ZERO |->
         rsp_res_re == 32'sd0 && rsp_res_im == 32'sd0)
      else $error("divide-by-zero word with nonzero parts");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted word not in first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_re))
      else $error("stalled output word lost");

endmodule

`default_nettype wire

// ===== bench/complex_arith_alu_top_test.sv =====
`timescale 1ns / 1ps

// Bench for the complex Q16.16 ALU. Words go in through the req_ channel,
// results come back through rsp_ in order; each accepted word is pushed onto
// a queue of predicted results that the response checker pops.
module complex_arith_alu_top_test;
   import caa_pkg::*;

   // Prediction of one result word
   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      status_type  status;
   } cplx_result_t;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic        [1:0]  req_mode;
   logic signed [31:0] req_a_re;
   logic signed [31:0] req_a_im;
   logic signed [31:0] req_b_re;
   logic signed [31:0] req_b_im;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_res_re;
   logic signed [31:0] rsp_res_im;
   logic        [1:0]  rsp_status;

   complex_arith_alu_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_a_re(req_a_re), .req_a_im(req_a_im),
      .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im), .rsp_status(rsp_status)
   );

   // Pending predictions, oldest first
   cplx_result_t pending_results[$];

   int unsigned send_idle_pct = 0;   // chance of a gap before each word
   int unsigned recv_stall_pct = 0;  // chance of rsp_ready low in a cycle
   int unsigned mismatches = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned mode_count[4];
   int unsigned status_count[4];
   int unsigned quiet_cycles = 0;

   localparam int unsigned PIPE_DEPTH = 36;
   localparam int unsigned WATCHDOG_LIMIT = 20000;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---- predictor ----

   // Saturate a sign/magnitude value to Q16.16; sets ovf on saturation.
   function automatic logic [31:0] sat_q16(input bit neg, input logic [63:0] mag,
                                            inout bit ovf);
      if (!neg) begin
         if (mag > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return mag[31:0];
      end
      if (mag > 64'h8000_0000) begin
         ovf = 1'b1;
         return 32'h8000_0000;
      end
      return 32'd0 - mag[31:0];
   endfunction

   // Split a wrapped 64-bit sum; 2^63 is taken as positive (it can only come
   // from two maximal positive products).
   function automatic void split_wide(input logic [63:0] u, output bit neg,
                                      output logic [63:0] mag);
      if (u == 64'h8000_0000_0000_0000) begin
         neg = 1'b0;
         mag = u;
      end else if (u[63]) begin
         neg = 1'b1;
         mag = -u;
      end else begin
         neg = 1'b0;
         mag = u;
      end
   endfunction

   function automatic logic [31:0] sum_q16(input longint s, inout bit ovf);
      if (s < 0) return sat_q16(1'b1, 64'(-s), ovf);
      return sat_q16(1'b0, 64'(s), ovf);
   endfunction

   function automatic logic [31:0] prod_q16(input logic [63:0] wide, inout bit ovf);
      bit          neg;
      logic [63:0] mag;
      split_wide(wide, neg, mag);
      return sat_q16(neg, mag >> 16, ovf);
   endfunction

   // Long division to 16 fraction bits, truncating toward zero
   function automatic logic [31:0] quot_q16(input logic [63:0] wide,
                                            input logic [63:0] den, inout bit ovf);
      bit          neg;
      logic [63:0] mag;
      logic [63:0] q0;
      logic [63:0] rem;
      logic [63:0] frac;
      split_wide(wide, neg, mag);
      q0 = mag / den;
      rem = mag % den;
      frac = 0;
      if (q0 >= 64'h1_0000) return sat_q16(neg, 64'hFFFF_FFFF_FFFF, ovf);
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         frac = frac << 1;
         if (rem >= den) begin
            rem = rem - den;
            frac[0] = 1'b1;
         end
      end
      return sat_q16(neg, (q0 << 16) | frac, ovf);
   endfunction

   function automatic cplx_result_t complex_result(input mode_type mode,
         input logic signed [31:0] a_re, input logic signed [31:0] a_im,
         input logic signed [31:0] b_re, input logic signed [31:0] b_im);
      cplx_result_t r;
      bit           ovf;
      longint       ar, ai, br, bi;
      logic [63:0]  den;
      ovf = 1'b0;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      r.re = '0;
      r.im = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_ADD: begin
            r.re = sum_q16(ar + br, ovf);
            r.im = sum_q16(ai + bi, ovf);
         end
         MODE_SUB: begin
            r.re = sum_q16(ar - br, ovf);
            r.im = sum_q16(ai - bi, ovf);
         end
         MODE_MUL: begin
            r.re = prod_q16(64'(ar * br - ai * bi), ovf);
            r.im = prod_q16(64'(ar * bi + ai * br), ovf);
         end
         default: begin
            den = 64'(br * br) + 64'(bi * bi);
            if (den == 0) r.status = STATUS_DIV_ZERO;
            else begin
               r.re = quot_q16(64'(ar * br + ai * bi), den, ovf);
               r.im = quot_q16(64'(ai * br - ar * bi), den, ovf);
            end
         end
      endcase
      if (r.status == STATUS_OK && ovf) r.status = STATUS_OVERFLOW;
      return r;
   endfunction

   // ---- driving ----

   // Present one word, wait for acceptance and record the prediction
   task automatic send_word(input mode_type mode, input logic [31:0] a_re,
                            input logic [31:0] a_im, input logic [31:0] b_re,
                            input logic [31:0] b_im);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_a_re <= a_re;
      req_a_im <= a_im;
      req_b_re <= b_re;
      req_b_im <= b_im;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(complex_result(mode, a_re, a_im, b_re, b_im));
      mode_count[mode]++;
      words_sent++;
   endtask

   // Operand mix: extremes, small values near zero, values within two units or one unit, full range
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(16)) - 8);
         3: return 32'($signed($urandom_range(32'h4_0000)) - 32'sh2_0000);
         4: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
         default: return $urandom;
      endcase
   endfunction

   // ---- checking ----

   always @(posedge clock) begin
      cplx_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         status_count[rsp_status]++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with nothing pending: re %h im %h st %0d",
                        $realtime, rsp_res_re, rsp_res_im, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_re !== want.re || rsp_res_im !== want.im
                || rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch: want re %h im %h st %0d, got re %h im %h st %0d",
                           $realtime, want.re, want.im, want.status,
                           rsp_res_re, rsp_res_im, rsp_status);
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // Watchdog: any handshake on either side resets the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", pending_results.size());
         $display("complex_arith_alu_top_test: errors");
         $finish;
      end
   end

   // ---- tests ----

   task automatic test_add_sub();
      send_word(MODE_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_0001);
      send_word(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_word(MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_word(MODE_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(MODE_SUB, 32'h1234_5678, 32'hFEDC_BA98, 32'h1234_5678, 32'h0000_0000);
   endtask

   task automatic test_multiply();
      send_word(MODE_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
      send_word(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // both products at -2^31 squared: wide sum lands on 2^63
      send_word(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_word(MODE_MUL, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
      // truncation toward zero of a tiny negative product
      send_word(MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
      send_word(MODE_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      send_word(MODE_MUL, 32'h00B5_0500, 32'h0000_0000, 32'hFF4A_FB00, 32'h0000_0000);
   endtask

   task automatic test_divide();
      // zero divisor
      send_word(MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
      send_word(MODE_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_word(MODE_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
      send_word(MODE_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
      // tiny divisor: quotient overflows
      send_word(MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
      send_word(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_word(MODE_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(MODE_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(MODE_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001);
   endtask

   task automatic test_random(input int unsigned n_words, input int unsigned idle_pct,
                              input int unsigned stall_pct);
      mode_type mode;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int unsigned i = 0; i < n_words; i++) begin
         mode = mode_type'($urandom_range(3));
         send_word(mode, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_ADD;
      req_a_re = '0;
      req_a_im = '0;
      req_b_re = '0;
      req_b_im = '0;
      rsp_ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_add_sub();
      test_multiply();
      test_divide();
      test_random(500, 0, 0);
      test_random(500, 86, 0);
      test_random(500, 0, 86);
      test_random(500, 31, 31);
      req_valid <= 1'b0;

      // drain, then a little slack for anything stray
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);

      $display("sent %0d words (add %0d, sub %0d, mul %0d, div %0d), checked %0d",
               words_sent, mode_count[MODE_ADD], mode_count[MODE_SUB],
               mode_count[MODE_MUL], mode_count[MODE_DIV], words_checked);
      $display("status seen: ok %0d, div-by-zero %0d, overflow %0d; mismatches %0d",
               status_count[STATUS_OK], status_count[STATUS_DIV_ZERO],
               status_count[STATUS_OVERFLOW], mismatches);
      if (mismatches == 0)
         $display("complex_arith_alu_top_test: clean");
      else
         $display("complex_arith_alu_top_test: errors");
      $finish;
   end

endmodule
